[hdl/tkd_pkg.sv]
// Shared types and constants for the terminal key decoder.
package tkd_pkg;

  localparam int KEY_W = 9;

  // Key codes on the result channel
  localparam logic [KEY_W-1:0] KEY_ESC    = 9'd27;
  localparam logic [KEY_W-1:0] KEY_CTRL_Q = 9'h011;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 9'd256;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 9'd257;
  localparam logic [KEY_W-1:0] KEY_UP     = 9'd258;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 9'd259;
  localparam logic [KEY_W-1:0] KEY_PGUP   = 9'd260;
  localparam logic [KEY_W-1:0] KEY_PGDN   = 9'd261;
  localparam logic [KEY_W-1:0] KEY_HOME   = 9'd262;
  localparam logic [KEY_W-1:0] KEY_END    = 9'd263;
  localparam logic [KEY_W-1:0] KEY_DEL    = 9'd264;

  // Bytes of interest
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRKT = 8'h5b;  // '['
  localparam logic [7:0] CH_O     = 8'h4f;  // 'O'
  localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'

  // Configuration register indexes
  localparam logic [1:0] REG_SCREEN_ROWS = 2'd0;
  localparam logic [1:0] REG_SCREEN_COLS = 2'd1;
  localparam logic [1:0] REG_FILE_ROWS   = 2'd2;

  localparam logic [7:0]  SCREEN_ROWS_RST = 8'd24;
  localparam logic [7:0]  SCREEN_COLS_RST = 8'd80;
  localparam logic [15:0] FILE_ROWS_RST   = 16'd0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_FIRST,
    PH_DIGIT
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]  screen_rows;
    logic [7:0]  screen_cols;
    logic [15:0] file_rows;
  } tkd_cfg_t;

  // One decoded key from the parser
  typedef struct packed {
    logic             have;
    logic [KEY_W-1:0] key;
  } tkd_key_evt_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [7:0]       cursor_col;
    logic [15:0]      cursor_line;
    logic [15:0]      scroll_offset;
    logic [7:0]       screen_line;
    logic             quit;
  } tkd_result_t;

endpackage

[hdl/tkd_if.sv]
// Valid/ready channel interfaces for terminal input and key results.
interface tkd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface tkd_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  key_code;
  logic [7:0]  cursor_col;
  logic [15:0] cursor_line;
  logic [15:0] scroll_offset;
  logic [7:0]  screen_line;
  logic        quit;

  modport source (output valid, output key_code, output cursor_col, output cursor_line,
                  output scroll_offset, output screen_line, output quit, input ready);
  modport sink   (input valid, input key_code, input cursor_col, input cursor_line,
                  input scroll_offset, input screen_line, input quit, output ready);
endinterface

[hdl/tkd_parse.sv]
// Escape sequence parser: turns bytes and timeouts into key events.
module tkd_parse
  import tkd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         func,
  input  logic [7:0]   in_byte,
  output tkd_key_evt_t evt
);

  parse_phase_t phase, phase_next;
  logic [7:0]   first_seq_byte, first_seq_byte_next;
  logic [7:0]   seq_digit, seq_digit_next;

  function automatic logic [KEY_W-1:0] decode_digit(input logic [7:0] d);
    logic [KEY_W-1:0] k;
    unique case (d)
      8'h35:        k = KEY_PGUP;  // '5'
      8'h36:        k = KEY_PGDN;  // '6'
      8'h31, 8'h37: k = KEY_HOME;  // '1' '7'
      8'h34, 8'h38: k = KEY_END;   // '4' '8'
      8'h33:        k = KEY_DEL;   // '3'
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [KEY_W-1:0] k;
    k = KEY_ESC;
    if (a == CH_LBRKT) begin
      unique case (b)
        8'h41:   k = KEY_UP;     // 'A'
        8'h42:   k = KEY_DOWN;   // 'B'
        8'h43:   k = KEY_RIGHT;  // 'C'
        8'h44:   k = KEY_LEFT;   // 'D'
        8'h48:   k = KEY_HOME;   // 'H'
        8'h46:   k = KEY_END;    // 'F'
        default: k = KEY_ESC;
      endcase
    end else if (a == CH_O) begin
      if (b == 8'h48) k = KEY_HOME;
      else if (b == 8'h46) k = KEY_END;
    end
    return k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      first_seq_byte <= 8'd0;
      seq_digit      <= 8'd0;
    end else if (adv) begin
      phase          <= phase_next;
      first_seq_byte <= first_seq_byte_next;
      seq_digit      <= seq_digit_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    first_seq_byte_next = first_seq_byte;
    seq_digit_next      = seq_digit;
    evt.have            = 1'b0;
    evt.key             = KEY_ESC;
    if (func) begin
      // timeout: flush a partial sequence as a bare escape
      if (phase != PH_IDLE) begin
        evt.have   = 1'b1;
        phase_next = PH_IDLE;
      end
    end else begin
      unique case (phase)
        PH_ESC: begin
          first_seq_byte_next = in_byte;
          phase_next          = PH_FIRST;
        end
        PH_FIRST: begin
          if (first_seq_byte == CH_LBRKT && in_byte >= 8'h30 && in_byte <= 8'h39) begin
            seq_digit_next = in_byte;
            phase_next     = PH_DIGIT;
          end else begin
            evt.have   = 1'b1;
            evt.key    = decode_pair(first_seq_byte, in_byte);
            phase_next = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          evt.have   = 1'b1;
          evt.key    = (in_byte == CH_TILDE) ? decode_digit(seq_digit) : KEY_ESC;
          phase_next = PH_IDLE;
        end
        PH_IDLE: begin
          if (in_byte == CH_ESC) begin
            phase_next = PH_ESC;
          end else begin
            evt.have = 1'b1;
            evt.key  = {1'b0, in_byte};
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

endmodule

[hdl/tkd_cursor.sv]
// Cursor position and scroll offset tracking per decoded key.
module tkd_cursor
  import tkd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  tkd_cfg_t     cfg,
  input  tkd_key_evt_t evt,
  output tkd_result_t  res
);

  logic [7:0]  col_pos, col_pos_next;
  logic [15:0] line_pos, line_pos_next;
  logic [15:0] top_line, top_line_next;

  logic [7:0]  last_col;
  logic [7:0]  rows;
  logic [16:0] line_plus_pg;
  logic [15:0] top_mid;
  logic        upd;

  assign upd = adv && evt.have;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= 8'd0;
      line_pos <= 16'd0;
      top_line <= 16'd0;
    end else if (upd) begin
      col_pos  <= col_pos_next;
      line_pos <= line_pos_next;
      top_line <= top_line_next;
    end
  end

  always_comb begin
    last_col      = (cfg.screen_cols != 8'd0) ? cfg.screen_cols - 8'd1 : 8'd0;
    rows          = (cfg.screen_rows != 8'd0) ? cfg.screen_rows : 8'd1;
    line_plus_pg  = {1'b0, line_pos} + {9'd0, cfg.screen_rows};
    col_pos_next  = col_pos;
    line_pos_next = line_pos;

    unique case (evt.key)
      KEY_LEFT:  if (col_pos != 8'd0) col_pos_next = col_pos - 8'd1;
      KEY_RIGHT: if (col_pos < last_col) col_pos_next = col_pos + 8'd1;
      KEY_UP:    if (line_pos != 16'd0) line_pos_next = line_pos - 16'd1;
      KEY_DOWN:  if (line_pos < cfg.file_rows) line_pos_next = line_pos + 16'd1;
      KEY_PGUP: begin
        line_pos_next = ({8'd0, cfg.screen_rows} < line_pos)
                        ? line_pos - {8'd0, cfg.screen_rows} : 16'd0;
      end
      KEY_PGDN: begin
        if (line_pos < cfg.file_rows) begin
          line_pos_next = (line_plus_pg > {1'b0, cfg.file_rows})
                          ? cfg.file_rows : line_plus_pg[15:0];
        end
      end
      KEY_HOME:  col_pos_next = 8'd0;
      KEY_END:   col_pos_next = last_col;
      default:   ;
    endcase

    // keep the cursor line inside the visible window
    top_mid = (line_pos_next < top_line) ? line_pos_next : top_line;
    if ({1'b0, line_pos_next} >= {1'b0, top_mid} + {9'd0, rows}) begin
      top_line_next = line_pos_next - {8'd0, rows} + 16'd1;
    end else begin
      top_line_next = top_mid;
    end

    res.key_code      = evt.key;
    res.cursor_col    = col_pos_next;
    res.cursor_line   = line_pos_next;
    res.scroll_offset = top_line_next;
    res.screen_line   = line_pos_next[7:0] - top_line_next[7:0];
    res.quit          = (evt.key == KEY_CTRL_Q);
  end

endmodule

[hdl/terminal_key_decode_cursor_control.sv]
// Top level: VT100 key decoder with cursor and scroll tracking.
// One beat enters on term per clock cycle when the pipeline can move: a beat is held in an
// input register until the result register is free or draining, then the parser and cursor
// logic run on it and a result beat, if the input finished a key, lands in the result
// register. Throughput is set only by the result register draining on report. A byte
// that opens or continues an escape sequence, and a timeout while idle, give no result.
// Keys: 0-255 plain byte, 256..264 left, right, up, down, page up, page down, home, end,
// delete; a broken or timed-out sequence reports a bare escape (27). quit flags ctrl-Q
// but the block keeps running. Configuration is written through wr_en/wr_index/wr_data;
// the user must write it only while the block is idle, as the block does not enforce it:
// index 0 screen_rows, 1 screen_cols, 2 file_rows; other indexes are ignored.
module terminal_key_decode_cursor_control
  import tkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tkd_in_if.sink      term,
  tkd_out_if.source   report,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  tkd_cfg_t     cfg;
  tkd_key_evt_t evt;
  tkd_result_t  res;
  tkd_result_t  out_data;

  // input register stage
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;
  logic       out_valid;
  logic       adv;

  // stage 1 moves when the result register is free or is being drained this cycle
  assign adv        = s1_valid && (!out_valid || report.ready);
  assign term.ready = !s1_valid || adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_rows <= SCREEN_ROWS_RST;
      cfg.screen_cols <= SCREEN_COLS_RST;
      cfg.file_rows   <= FILE_ROWS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_ROWS: cfg.screen_rows <= wr_data[7:0];
        REG_SCREEN_COLS: cfg.screen_cols <= wr_data[7:0];
        REG_FILE_ROWS:   cfg.file_rows   <= wr_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (term.ready) begin
      s1_valid <= term.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term.valid && term.ready) begin
      s1_func <= term.func;
      s1_byte <= term.in_byte;
    end
  end

  tkd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .func    (s1_func),
    .in_byte (s1_byte),
    .evt     (evt)
  );

  tkd_cursor u_cursor (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cfg (cfg),
    .evt (evt),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && evt.have) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && evt.have) begin
      out_data <= res;
    end
  end

  assign report.valid         = out_valid;
  assign report.key_code      = out_data.key_code;
  assign report.cursor_col    = out_data.cursor_col;
  assign report.cursor_line   = out_data.cursor_line;
  assign report.scroll_offset = out_data.scroll_offset;
  assign report.screen_line   = out_data.screen_line;
  assign report.quit          = out_data.quit;

endmodule
